[design/wht_pkg.sv]
// Shared types, constants and a helper function for the water heater thermostat.
`default_nettype none

package wht_pkg;

	localparam int SPA_DEFAULT      = 10;
	localparam int ADC_BITS_DEFAULT = 10;

	localparam int KIND_W     = 2;
	localparam int ADC_IN_W   = 10;
	localparam int SETPOINT_W = 7;
	localparam int STEP_W     = 4;
	localparam int BAND_W     = 5;
	localparam int PERIOD_W   = 10;
	localparam int IDLE_W     = 14;
	localparam int AVG_W      = 9;
	localparam int DIGIT_W    = 4;
	localparam int CMP_W      = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	localparam int AVG_SCALE = 500;

	localparam logic [SETPOINT_W-1:0] RST_SP_MIN   = 7'd35;
	localparam logic [SETPOINT_W-1:0] RST_SP_MAX   = 7'd75;
	localparam logic [STEP_W-1:0]     RST_SP_STEP  = 4'd5;
	localparam logic [BAND_W-1:0]     RST_BAND     = 5'd5;
	localparam logic [PERIOD_W-1:0]   RST_PERIOD   = 10'd100;
	localparam logic [IDLE_W-1:0]     RST_IDLE     = 14'd5000;
	localparam logic [SETPOINT_W-1:0] RST_SETPOINT = 7'd60;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK = 2'd0,
		KIND_UP   = 2'd1,
		KIND_DOWN = 2'd2
	} wht_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SP_MIN  = 3'd0,
		CFG_SP_MAX  = 3'd1,
		CFG_SP_STEP = 3'd2,
		CFG_BAND    = 3'd3,
		CFG_PERIOD  = 3'd4,
		CFG_IDLE    = 3'd5
	} wht_cfg_idx_t;

	// Outcome of one tick for the averaging unit, as seen by the control logic.
	typedef struct packed {
		logic             done;
		logic [AVG_W-1:0] average;
	} wht_avg_t;

	// Setpoint divided by ten: multiply by 205 and drop 11 bits, exact below 1029.
	function automatic logic [DIGIT_W-1:0] div10(input logic [SETPOINT_W-1:0] x);
		logic [SETPOINT_W+8-1:0] prod;
		begin
			prod = {8'd0, x} * (SETPOINT_W+8)'(205);
			div10 = prod[11 +: DIGIT_W];
		end
	endfunction

endpackage

`default_nettype wire

[design/wht_sampler.sv]
// Sample pacing, accumulation and fixed-point averaging of converter readings.
`default_nettype none

module wht_sampler
	import wht_pkg::*;
#(
	parameter int SAMPLES_PER_AVERAGE = SPA_DEFAULT,
	parameter int ADC_BITS            = ADC_BITS_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                tick_en,
	input  wire logic [ADC_IN_W-1:0] adc,
	input  wire logic [PERIOD_W-1:0] period,
	output wht_avg_t                 avg_next,
	output logic      [AVG_W-1:0]    avg
);

	localparam int FULL   = (1 << ADC_BITS) - 1;
	localparam int DEN    = SAMPLES_PER_AVERAGE * FULL;
	localparam int SUM_W  = $clog2(DEN + 1);
	localparam int CNT_W  = $clog2(SAMPLES_PER_AVERAGE + 1);
	localparam int EXT_W  = (ADC_IN_W > ADC_BITS) ? ADC_IN_W : ADC_BITS;
	localparam int SH     = 2 * $clog2(DEN + 1);
	localparam logic [63:0] RECIP64 =
		((64'(AVG_SCALE) << SH) + 64'(DEN) - 64'd1) / 64'(DEN);
	localparam int M_W    = $clog2(RECIP64 + 64'd1);
	localparam int PROD_W = (SUM_W + M_W > SH + AVG_W) ? SUM_W + M_W : SH + AVG_W;

	logic [PERIOD_W-1:0] ticks_q;
	logic [CNT_W-1:0]    count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [AVG_W-1:0]    avg_q;

	logic [PERIOD_W-1:0] ticks_inc;
	logic                take;
	logic [EXT_W-1:0]    adc_ext;
	logic [ADC_BITS-1:0] adc_sat;
	logic [SUM_W-1:0]    sum_inc;
	logic [CNT_W-1:0]    count_inc;
	logic                done;
	logic [PROD_W-1:0]   prod;

	// The reciprocal has 2*clog2(DEN+1) fraction bits, so the floor of the product is exact.
	always_comb begin
		ticks_inc = ticks_q + PERIOD_W'(1);
		take      = (ticks_inc >= period);
		adc_ext   = EXT_W'(adc);
		adc_sat   = (adc_ext > EXT_W'(FULL)) ? ADC_BITS'(FULL) : adc_ext[ADC_BITS-1:0];
		sum_inc   = sum_q + SUM_W'(adc_sat);
		count_inc = count_q + CNT_W'(1);
		done      = take && (count_inc >= CNT_W'(SAMPLES_PER_AVERAGE));
		prod      = PROD_W'(sum_inc) * PROD_W'(RECIP64[M_W-1:0]);
		avg_next.done    = tick_en && done;
		avg_next.average = (tick_en && done) ? prod[SH +: AVG_W] : avg_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= '0;
			count_q <= '0;
			sum_q   <= '0;
			avg_q   <= '0;
		end else if (tick_en) begin
			if (take) begin
				ticks_q <= '0;
				if (done) begin
					count_q <= '0;
					sum_q   <= '0;
					avg_q   <= prod[SH +: AVG_W];
				end else begin
					count_q <= count_inc;
					sum_q   <= sum_inc;
				end
			end else begin
				ticks_q <= ticks_inc;
			end
		end
	end

	assign avg = avg_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(SAMPLES_PER_AVERAGE))
		else $error("sample count reached the average length");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sum_q) <= 32'(count_q) * 32'(FULL))
		else $error("sample sum exceeds the count of full-scale samples");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_en |=> $stable(sum_q) && $stable(avg_q))
		else $error("accumulator changed without a tick");

endmodule

`default_nettype wire

[design/water_heater_thermostat.sv]
// Top level of the water heater thermostat: input stage, event logic and result register.
// An item accepted into the input register has its result written to the result registers.
// Throughput: one item per cycle unless the result stalls; the event and control update
// is a single pass between the input register and the state/result registers.
// A stalled result holds the state; the input register still takes one more item.
// Reset sets the setpoint to 60 and the digit to 6, clears counters and the other outputs, and lights the display.
`default_nettype none

module water_heater_thermostat
	import wht_pkg::*;
#(
	parameter int SAMPLES_PER_AVERAGE = SPA_DEFAULT,
	parameter int ADC_BITS            = ADC_BITS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [KIND_W-1:0]     kind,
	input  wire logic [ADC_IN_W-1:0]   adc_sample,
	input  wire logic                  button_held,
	input  wire logic                  power_on,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       heater_on,
	output logic                       cooler_on,
	output logic                       status_led,
	output logic                       heat_blink_led,
	output logic                       display_on,
	output logic [DIGIT_W-1:0]         display_digit,
	output logic [SETPOINT_W-1:0]      setpoint,
	output logic [AVG_W-1:0]           average_temp
);

	logic [SETPOINT_W-1:0] sp_min_q;
	logic [SETPOINT_W-1:0] sp_max_q;
	logic [STEP_W-1:0]     sp_step_q;
	logic [BAND_W-1:0]     band_q;
	logic [PERIOD_W-1:0]   period_q;
	logic [IDLE_W-1:0]     idle_timeout_q;

	logic                  valid_s1;
	logic [KIND_W-1:0]     kind_s1;
	logic [ADC_IN_W-1:0]   adc_s1;
	logic                  held_s1;
	logic                  power_s1;

	logic                  out_valid_q;
	logic [SETPOINT_W-1:0] required_q;
	logic [IDLE_W-1:0]     idle_q;
	logic                  display_q;
	logic                  heater_q;
	logic                  cooler_q;
	logic                  status_q;
	logic                  blink_q;
	logic [DIGIT_W-1:0]    digit_q;

	logic                  advance;
	logic                  fire;
	logic                  tick_en;
	wht_avg_t              avg_next;
	logic [AVG_W-1:0]      avg_cur;

	logic [SETPOINT_W-1:0] required_d;
	logic [IDLE_W-1:0]     idle_d;
	logic                  display_d;
	logic                  heater_d;
	logic                  cooler_d;
	logic                  status_d;
	logic                  blink_d;
	logic [SETPOINT_W:0]   sp_up;
	logic [SETPOINT_W:0]   sp_floor;
	logic [IDLE_W-1:0]     idle_inc;
	logic [CMP_W-1:0]      sp_ext;
	logic [CMP_W-1:0]      av_ext;
	logic [CMP_W-1:0]      band_ext;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign tick_en  = fire && (kind_s1 == KIND_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_min_q       <= RST_SP_MIN;
			sp_max_q       <= RST_SP_MAX;
			sp_step_q      <= RST_SP_STEP;
			band_q         <= RST_BAND;
			period_q       <= RST_PERIOD;
			idle_timeout_q <= RST_IDLE;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SP_MIN:  sp_min_q       <= cfg_data[SETPOINT_W-1:0];
				CFG_SP_MAX:  sp_max_q       <= cfg_data[SETPOINT_W-1:0];
				CFG_SP_STEP: sp_step_q      <= cfg_data[STEP_W-1:0];
				CFG_BAND:    band_q         <= cfg_data[BAND_W-1:0];
				CFG_PERIOD:  period_q       <= cfg_data[PERIOD_W-1:0];
				CFG_IDLE:    idle_timeout_q <= cfg_data[IDLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			kind_s1  <= kind;
			adc_s1   <= adc_sample;
			held_s1  <= button_held;
			power_s1 <= power_on;
		end
	end

	wht_sampler #(
		.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE),
		.ADC_BITS(ADC_BITS)
	) u_sampler (
		.clk(clk),
		.arst_n(arst_n),
		.tick_en(tick_en),
		.adc(adc_s1),
		.period(period_q),
		.avg_next(avg_next),
		.avg(avg_cur)
	);

	always_comb begin
		required_d = required_q;
		idle_d     = idle_q;
		display_d  = display_q;
		heater_d   = heater_q;
		cooler_d   = cooler_q;
		status_d   = status_q;
		blink_d    = blink_q;
		sp_up      = {1'b0, required_q} + (SETPOINT_W+1)'(sp_step_q);
		sp_floor   = {1'b0, sp_min_q} + (SETPOINT_W+1)'(sp_step_q);
		idle_inc   = idle_q + IDLE_W'(1);

		case (kind_s1)
			KIND_TICK: begin
				if (avg_next.done && heater_q) begin
					blink_d = !blink_q;
				end
				if (!held_s1) begin
					if (idle_inc >= idle_timeout_q) begin
						display_d = 1'b0;
						idle_d    = '0;
					end else begin
						idle_d = idle_inc;
					end
				end else begin
					idle_d = '0;
				end
			end
			KIND_UP: begin
				if (required_q < sp_max_q) begin
					required_d = (sp_up > {1'b0, sp_max_q}) ? sp_max_q : sp_up[SETPOINT_W-1:0];
					display_d  = 1'b1;
				end
			end
			KIND_DOWN: begin
				if (required_q > sp_min_q) begin
					required_d = ({1'b0, required_q} >= sp_floor)
						? required_q - SETPOINT_W'(sp_step_q) : sp_min_q;
					display_d  = 1'b1;
				end
			end
			default: begin
			end
		endcase

		sp_ext   = CMP_W'(required_d);
		av_ext   = CMP_W'(avg_next.average);
		band_ext = CMP_W'(band_q);
		if (power_s1 && (avg_next.average != '0)) begin
			if (sp_ext == av_ext + band_ext) begin
				heater_d = 1'b1;
				cooler_d = 1'b0;
			end
			if (av_ext == sp_ext + band_ext) begin
				cooler_d = 1'b1;
				heater_d = 1'b0;
				status_d = 1'b1;
			end
			if (sp_ext == av_ext) begin
				heater_d = 1'b0;
				cooler_d = 1'b0;
				status_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			required_q  <= RST_SETPOINT;
			idle_q      <= '0;
			display_q   <= 1'b1;
			heater_q    <= 1'b0;
			cooler_q    <= 1'b0;
			status_q    <= 1'b0;
			blink_q     <= 1'b0;
			digit_q     <= div10(RST_SETPOINT);
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				required_q <= required_d;
				idle_q     <= idle_d;
				display_q  <= display_d;
				heater_q   <= heater_d;
				cooler_q   <= cooler_d;
				status_q   <= status_d;
				blink_q    <= blink_d;
				digit_q    <= div10(required_d);
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign heater_on      = heater_q;
	assign cooler_on      = cooler_q;
	assign status_led     = status_q;
	assign heat_blink_led = blink_q;
	assign display_on     = display_q;
	assign display_digit  = digit_q;
	assign setpoint       = required_q;
	assign average_temp   = avg_cur;

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(heater_q && cooler_q))
		else $error("heater and cooler driven together");

	a_cool_status: assert property (@(posedge clk) disable iff (!arst_n)
		cooler_q |-> status_q)
		else $error("cooler on without the status LED");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(required_q) && $stable(average_temp)
			&& $stable(heater_q) && $stable(blink_q))
		else $error("thermostat state moved while the result was stalled");

	a_digit_match: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> digit_q == div10(required_q))
		else $error("display digit out of step with the setpoint");

endmodule

`default_nettype wire

[test/water_heater_thermostat_test.sv]
// Self-checking testbench for the water heater thermostat with a cycle-free event predictor.
`timescale 1ns / 100ps

module water_heater_thermostat_test;
	import wht_pkg::*;

	localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int ADC_FULL      = (1 << ADC_BITS_DEFAULT) - 1;

	typedef struct packed {
		logic                  heater;
		logic                  cooler;
		logic                  status;
		logic                  blink;
		logic                  disp;
		logic [DIGIT_W-1:0]    digit;
		logic [SETPOINT_W-1:0] sp;
		logic [AVG_W-1:0]      avg;
	} thermo_out_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [KIND_W-1:0]     kind = '0;
	logic [ADC_IN_W-1:0]   adc_sample = '0;
	logic                  button_held = 1'b0;
	logic                  power_on = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  heater_on;
	logic                  cooler_on;
	logic                  status_led;
	logic                  heat_blink_led;
	logic                  display_on;
	logic [DIGIT_W-1:0]    display_digit;
	logic [SETPOINT_W-1:0] setpoint;
	logic [AVG_W-1:0]      average_temp;

	water_heater_thermostat dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.adc_sample(adc_sample),
		.button_held(button_held),
		.power_on(power_on),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.heater_on(heater_on),
		.cooler_on(cooler_on),
		.status_led(status_led),
		.heat_blink_led(heat_blink_led),
		.display_on(display_on),
		.display_digit(display_digit),
		.setpoint(setpoint),
		.average_temp(average_temp)
	);

	// Predicted thermostat settings and state.
	logic [SETPOINT_W-1:0] cfg_min = RST_SP_MIN;
	logic [SETPOINT_W-1:0] cfg_max = RST_SP_MAX;
	logic [STEP_W-1:0]     cfg_step = RST_SP_STEP;
	logic [BAND_W-1:0]     cfg_band = RST_BAND;
	logic [PERIOD_W-1:0]   cfg_period = RST_PERIOD;
	logic [IDLE_W-1:0]     cfg_idle = RST_IDLE;

	logic [SETPOINT_W-1:0] sp_q = RST_SETPOINT;
	logic [PERIOD_W-1:0]   tick_cnt = '0;
	int                    samples_seen = 0;
	int                    sample_sum = 0;
	logic [AVG_W-1:0]      avg_q = '0;
	logic [IDLE_W-1:0]     idle_cnt = '0;
	logic                  disp_q = 1'b1;
	logic                  heat_q = 1'b0;
	logic                  cool_q = 1'b0;
	logic                  stat_q = 1'b0;
	logic                  blink_q = 1'b0;

	thermo_out_t pending_outputs[$];

	int  mismatch_count = 0;
	int  events_sent = 0;
	int  outputs_checked = 0;
	int  averages_formed = 0;
	int  display_blanks = 0;
	int  settings_applied = 0;
	int  hold_requests = 0;
	int  holds_done = 0;
	bit  idle_enable = 1'b1;
	bit  valid_held = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#200_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(15, 50);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [ADC_IN_W-1:0] adc_for_average(input int target);
		int level;
		level = (target * ADC_FULL + AVG_SCALE - 1) / AVG_SCALE;
		if (level > ADC_FULL)
			level = ADC_FULL;
		if (level < 0)
			level = 0;
		return ADC_IN_W'(level);
	endfunction

	task automatic thermostat_predict(input logic [KIND_W-1:0] k, input logic [ADC_IN_W-1:0] adc,
			input logic held, input logic pwr);
		int          next_sp;
		int          sp_i;
		int          av_i;
		int          band_i;
		thermo_out_t res;
		case (k)
			KIND_TICK: begin
				tick_cnt = tick_cnt + 1'b1;
				if (tick_cnt >= cfg_period) begin
					tick_cnt = '0;
					sample_sum += int'(adc);
					samples_seen++;
					if (samples_seen >= SPA_DEFAULT) begin
						avg_q = AVG_W'((sample_sum * AVG_SCALE) / (SPA_DEFAULT * ADC_FULL));
						sample_sum = 0;
						samples_seen = 0;
						averages_formed++;
						if (heat_q)
							blink_q = !blink_q;
					end
				end
				if (!held) begin
					idle_cnt = idle_cnt + 1'b1;
					if (idle_cnt >= cfg_idle) begin
						if (disp_q)
							display_blanks++;
						disp_q = 1'b0;
						idle_cnt = '0;
					end
				end else begin
					idle_cnt = '0;
				end
			end
			KIND_UP: begin
				if (sp_q < cfg_max) begin
					next_sp = int'(sp_q) + int'(cfg_step);
					sp_q = (next_sp > int'(cfg_max)) ? cfg_max : SETPOINT_W'(next_sp);
					disp_q = 1'b1;
				end
			end
			KIND_DOWN: begin
				if (sp_q > cfg_min) begin
					if (int'(sp_q) >= int'(cfg_min) + int'(cfg_step))
						sp_q = SETPOINT_W'(int'(sp_q) - int'(cfg_step));
					else
						sp_q = cfg_min;
					disp_q = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (pwr && avg_q != '0) begin
			sp_i = int'(sp_q);
			av_i = int'(avg_q);
			band_i = int'(cfg_band);
			if (sp_i - av_i == band_i) begin
				heat_q = 1'b1;
				cool_q = 1'b0;
			end
			if (av_i - sp_i == band_i) begin
				cool_q = 1'b1;
				heat_q = 1'b0;
				stat_q = 1'b1;
			end
			if (sp_i == av_i) begin
				cool_q = 1'b0;
				heat_q = 1'b0;
				stat_q = 1'b0;
			end
		end

		res.heater = heat_q;
		res.cooler = cool_q;
		res.status = stat_q;
		res.blink  = blink_q;
		res.disp   = disp_q;
		res.digit  = DIGIT_W'(sp_q / 10);
		res.sp     = sp_q;
		res.avg    = avg_q;
		pending_outputs.push_back(res);
	endtask

	task automatic send_event(input logic [KIND_W-1:0] k, input logic [ADC_IN_W-1:0] adc,
			input logic held, input logic pwr);
		int gap;
		in_valid <= 1'b1;
		kind <= k;
		adc_sample <= adc;
		button_held <= held;
		power_on <= pwr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		thermostat_predict(k, adc, held, pwr);
		events_sent++;
		gap = (idle_enable && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			valid_held = 1'b0;
			repeat (gap) @(posedge clk);
		end else begin
			valid_held = 1'b1;
		end
	endtask

	task automatic end_burst();
		if (valid_held) begin
			in_valid <= 1'b0;
			valid_held = 1'b0;
		end
	endtask

	task automatic settle();
		end_burst();
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input wht_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_SP_MIN:  cfg_min = data[SETPOINT_W-1:0];
			CFG_SP_MAX:  cfg_max = data[SETPOINT_W-1:0];
			CFG_SP_STEP: cfg_step = data[STEP_W-1:0];
			CFG_BAND:    cfg_band = data[BAND_W-1:0];
			CFG_PERIOD:  cfg_period = data[PERIOD_W-1:0];
			CFG_IDLE:    cfg_idle = data[IDLE_W-1:0];
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input int sp_min, input int sp_max, input int step, input int band,
			input int period, input int idle);
		settle();
		write_reg(CFG_SP_MIN, CFG_DATA_W'(sp_min));
		write_reg(CFG_SP_MAX, CFG_DATA_W'(sp_max));
		write_reg(CFG_SP_STEP, CFG_DATA_W'(step));
		write_reg(CFG_BAND, CFG_DATA_W'(band));
		write_reg(CFG_PERIOD, CFG_DATA_W'(period));
		write_reg(CFG_IDLE, CFG_DATA_W'(idle));
		cfg_write <= 1'b0;
		settings_applied++;
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// Receiver: random stalls, plus long hold-offs on request.
	initial begin
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				holds_done++;
			end else if (idle_enable && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat (pick_gap()) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		thermo_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outputs.size() == 0) begin
				$error("output item with no prediction waiting");
				mismatch_count++;
			end else begin
				want = pending_outputs.pop_front();
				compare_field("heater_on", int'(want.heater), int'(heater_on));
				compare_field("cooler_on", int'(want.cooler), int'(cooler_on));
				compare_field("status_led", int'(want.status), int'(status_led));
				compare_field("heat_blink_led", int'(want.blink), int'(heat_blink_led));
				compare_field("display_on", int'(want.disp), int'(display_on));
				compare_field("display_digit", int'(want.digit), int'(display_digit));
				compare_field("setpoint", int'(want.sp), int'(setpoint));
				compare_field("average_temp", int'(want.avg), int'(average_temp));
				outputs_checked++;
			end
		end
	end

	task automatic test_reset_state();
		send_event(KIND_NOP, '0, 1'b0, 1'b0);
		send_event(KIND_NOP, '1, 1'b1, 1'b1);
	endtask

	task automatic test_setpoint_buttons();
		repeat (4) send_event(KIND_UP, '0, 1'b1, 1'b0);
		set_config(0, 127, 15, RST_BAND, RST_PERIOD, RST_IDLE);
		repeat (4) send_event(KIND_UP, ADC_IN_W'($urandom), 1'b0, 1'b1);
		repeat (2) send_event(KIND_DOWN, ADC_IN_W'($urandom), 1'b1, 1'b1);
		send_event(KIND_TICK, '1, 1'b1, 1'b1);
	endtask

	task automatic test_average_extremes();
		set_config(0, 127, 15, RST_BAND, 1, 16383);
		repeat (SPA_DEFAULT) send_event(KIND_TICK, '1, 1'b0, 1'b1);
	endtask

	task automatic test_backpressure();
		set_config(RST_SP_MIN, RST_SP_MAX, RST_SP_STEP, RST_BAND, 2, 40);
		idle_enable = 1'b0;
		hold_requests++;
		repeat (40) send_event(KIND_TICK, ADC_IN_W'($urandom), 1'($urandom_range(0, 1)), 1'b1);
		settle();
		idle_enable = 1'b1;
	endtask

	task automatic test_random_phases();
		int                  phase;
		int                  sent;
		int                  burst;
		int                  target;
		int                  choice;
		int                  i;
		int                  sp_min;
		int                  sp_max;
		int                  step;
		int                  band;
		int                  idle;
		logic [ADC_IN_W-1:0] level;
		for (phase = 0; phase < 18; phase++) begin
			case ($urandom_range(0, 4))
				0: sp_min = 0;
				1: sp_min = 127;
				default: sp_min = $urandom_range(20, 60);
			endcase
			case ($urandom_range(0, 4))
				0: sp_max = 127;
				1: sp_max = 0;
				default: sp_max = $urandom_range(60, 127);
			endcase
			case ($urandom_range(0, 7))
				0: step = 0;
				1: step = 1;
				2: step = 15;
				default: step = $urandom_range(1, 15);
			endcase
			case ($urandom_range(0, 4))
				0: band = 0;
				1: band = 31;
				default: band = $urandom_range(0, 8);
			endcase
			case ($urandom_range(0, 5))
				0: idle = 0;
				1: idle = 1;
				2: idle = 16383;
				default: idle = $urandom_range(2, 80);
			endcase
			set_config(sp_min, sp_max, step, band, $urandom_range(0, 3), idle);
			idle_enable = ($urandom_range(0, 3) != 0);
			sent = 0;
			while (sent < 55) begin
				choice = $urandom_range(0, 9);
				if (choice < 6) begin
					// Aim the average at a switching point so the control logic acts, or at a random level.
					case ($urandom_range(0, 3))
						0: target = int'(sp_q) + int'(cfg_band);
						1: target = int'(sp_q) - int'(cfg_band);
						2: target = int'(sp_q);
						default: target = $urandom_range(0, 500);
					endcase
					level = adc_for_average(target);
					burst = $urandom_range(5, 11 * (int'(cfg_period) + 1));
					for (i = 0; i < burst; i++)
						send_event(KIND_TICK,
							($urandom_range(0, 9) == 0) ? ADC_IN_W'($urandom) : level,
							$urandom_range(0, 7) == 0, $urandom_range(0, 7) != 0);
					sent += burst;
				end else if (choice < 9) begin
					burst = $urandom_range(1, 4);
					for (i = 0; i < burst; i++)
						send_event($urandom_range(0, 1) ? KIND_UP : KIND_DOWN,
							ADC_IN_W'($urandom), 1'($urandom_range(0, 1)),
							$urandom_range(0, 7) != 0);
					sent += burst;
				end else begin
					send_event(KIND_W'($urandom_range(0, 3)), ADC_IN_W'($urandom),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
					sent++;
				end
			end
		end
		idle_enable = 1'b1;
	endtask

	task automatic test_long_counters();
		set_config(RST_SP_MIN, RST_SP_MAX, 1, 31, 300, 320);
		idle_enable = 1'b0;
		send_event(KIND_DOWN, '0, 1'b0, 1'b1);
		repeat (330) send_event(KIND_TICK, ADC_IN_W'($urandom), 1'b0, 1'b1);
		idle_enable = 1'b1;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_state();
		test_setpoint_buttons();
		test_average_extremes();
		test_backpressure();
		test_random_phases();
		test_long_counters();
		settle();
		repeat (10) @(posedge clk);
		$display("Checked %0d outputs from %0d events over %0d register settings.",
			outputs_checked, events_sent, settings_applied);
		$display("The run formed %0d averages and blanked the display %0d times.",
			averages_formed, display_blanks);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
